### src/cd_sector_framer_assert.svh
// Assertion macros for the CD sector framer.
`ifndef CD_SECTOR_FRAMER_ASSERT_SVH
`define CD_SECTOR_FRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CDSF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cd_sector_framer: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CDSF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cd_sector_framer: check failed");

`endif

### src/cdsf_pkg.sv
// Constants and helper functions for the CD sector framer.
`timescale 1ns / 1ps
`default_nettype none

package cdsf_pkg;

	localparam int unsigned POS_W   = 9;   // word position within a raw sector
	localparam int unsigned WIDX_W  = 8;   // input word index within a user sector
	localparam int unsigned FRAME_W = 7;
	localparam int unsigned SEC_W   = 6;
	localparam int unsigned MIN_W   = 6;

	localparam logic [POS_W-1:0]   LAST_POS      = POS_W'(2352 / 8 - 1);
	localparam logic [WIDX_W-1:0]  LAST_WIDX     = 8'hFF;
	localparam logic [FRAME_W-1:0] LAST_FRAME    = FRAME_W'(75 - 1);
	localparam logic [SEC_W-1:0]   LAST_SECOND   = SEC_W'(60 - 1);
	localparam logic [MIN_W-1:0]   LAST_MINUTE   = MIN_W'(60 - 1);

	localparam logic [63:0] SYNC_WORD   = 64'hFFFF_FFFF_FFFF_FF00;
	localparam logic [63:0] SUBHDR_WORD = 64'h0000_0000_0020_0001;
	localparam logic [23:0] SYNC_TAIL   = 24'hFF_FFFF;

	// Register indexes on the config port.
	localparam logic [0:0] REG_MODE_TWO    = 1'b0;
	localparam logic [0:0] REG_SCRAMBLE_ON = 1'b1;

	// Repeating scramble key.
	function automatic logic [7:0] key_byte(input logic [3:0] idx);
		logic [7:0] k;
		unique case (idx)
			4'd0:    k = 8'hAA;
			4'd1:    k = 8'hBB;
			4'd2:    k = 8'hCC;
			4'd3:    k = 8'hDD;
			4'd4:    k = 8'hEE;
			4'd5:    k = 8'hFF;
			4'd6:    k = 8'h11;
			4'd7:    k = 8'h22;
			4'd8:    k = 8'h33;
			4'd9:    k = 8'h44;
			default: k = 8'h00;
		endcase
		return k;
	endfunction

	// Key index of byte 0 of word pos: (8*pos - 12) mod 10 = 10 - 2*((pos+1) mod 5).
	// (pos+1) mod 5 by nibble folding (16 = 1 mod 5) and three compare-subtracts.
	function automatic logic [3:0] key_phase(input logic [POS_W-1:0] pos);
		logic [POS_W-1:0] p1;
		logic [4:0]       s;
		logic [3:0]       r;
		p1 = pos + POS_W'(1);
		s  = 5'(p1[8]) + 5'(p1[7:4]) + 5'(p1[3:0]);
		if (s >= 5'd20) s = s - 5'd20;
		if (s >= 5'd10) s = s - 5'd10;
		if (s >= 5'd5)  s = s - 5'd5;
		r = s[3:0];
		return (r == 4'd0) ? 4'd0 : 4'(4'd10 - {r[2:0], 1'b0});
	endfunction

endpackage

`default_nettype wire

### src/cd_sector_framer.sv
// The first result word of an item passes the stage-1 job register, then the stage-2
//   output register. Throughput: one word out per cycle while out_stall is low, as set
//   by the single output word generator; a middle item yields one word, the first item
//   of a sector 3 (mode 1) or 4 (mode 2), the last 37 or 36: 294 words per 256 items.
// Reset (arst_n, asynchronous, active low) clears the config registers, the sector
//   counters and all valid flags.
`timescale 1ns / 1ps
`default_nettype none

module cd_sector_framer
	import cdsf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config write port
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [0:0]  cfg_data,
	// user data in
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] data_word,
	// raw sector out
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      raw_word,
	output logic             last_of_run,
	output logic             sector_end
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic mode_two_q, scramble_on_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_two_q    <= 1'b0;
			scramble_on_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE_TWO:    mode_two_q    <= cfg_data[0];
				REG_SCRAMBLE_ON: scramble_on_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sector state: input word index and the minute/second/frame address
	// ------------------------------------------------------------------
	logic [WIDX_W-1:0]  widx_q;
	logic [FRAME_W-1:0] frame_q;
	logic [SEC_W-1:0]   second_q;
	logic [MIN_W-1:0]   minute_q;

	// ------------------------------------------------------------------
	// Stage 1: the job held for the item just taken in. pos_s1 walks over
	// the raw-sector word positions this item produces; last_pos_s1 is the
	// final one. Config and address are snapshotted with the item so every
	// word follows the values at its own input transfer.
	// ------------------------------------------------------------------
	logic              job_valid_s1;
	logic [63:0]       data_s1;
	logic              mode_s1, scr_s1;
	logic              tail_s1;      // item closes the sector
	logic [POS_W-1:0]  pos_s1, data_pos_s1, last_pos_s1;
	logic [FRAME_W-1:0] frame_s1;
	logic [SEC_W-1:0]  second_s1;
	logic [MIN_W-1:0]  minute_s1;

	// Stage 2: output register
	logic              out_valid_s2;
	logic [63:0]       raw_word_s2;
	logic              last_s2, end_s2;

	logic in_xfer, emit, job_done;
	logic [POS_W-1:0] hdr_words, data_pos_new;

	assign emit     = job_valid_s1 && (!out_valid_s2 || !out_stall);
	assign job_done = emit && (pos_s1 == last_pos_s1);
	// Next item may enter in the very cycle the current job issues its last word.
	assign in_stall = job_valid_s1 && !job_done;
	assign in_xfer  = in_valid && !in_stall;

	assign hdr_words    = mode_two_q ? POS_W'(3) : POS_W'(2);
	assign data_pos_new = hdr_words + POS_W'(widx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q   <= '0;
			frame_q  <= '0;
			second_q <= '0;
			minute_q <= '0;
		end else if (in_xfer) begin
			widx_q <= widx_q + WIDX_W'(1);
			if (widx_q == LAST_WIDX) begin
				// address carry: frames -> seconds -> minutes, minutes wrap
				if (frame_q == LAST_FRAME) begin
					frame_q <= '0;
					if (second_q == LAST_SECOND) begin
						second_q <= '0;
						minute_q <= (minute_q == LAST_MINUTE) ? '0 : minute_q + MIN_W'(1);
					end else begin
						second_q <= second_q + SEC_W'(1);
					end
				end else begin
					frame_q <= frame_q + FRAME_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			job_valid_s1 <= 1'b1;
		end else if (job_done) begin
			job_valid_s1 <= 1'b0;
		end
	end

	// Job payload: no reset needed.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			data_s1     <= data_word;
			mode_s1     <= mode_two_q;
			scr_s1      <= scramble_on_q;
			tail_s1     <= (widx_q == LAST_WIDX);
			data_pos_s1 <= data_pos_new;
			// first item of a sector starts at the sync word
			pos_s1      <= (widx_q == '0) ? '0 : data_pos_new;
			last_pos_s1 <= (widx_q == LAST_WIDX) ? LAST_POS : data_pos_new;
			frame_s1    <= frame_q;
			second_s1   <= second_q;
			minute_s1   <= minute_q;
		end else if (emit) begin
			pos_s1 <= pos_s1 + POS_W'(1);
		end
	end

	// ------------------------------------------------------------------
	// Word generation for position pos_s1
	// ------------------------------------------------------------------
	logic [63:0] plain_word, scr_word;
	logic [3:0]  phase;

	always_comb begin
		priority if (pos_s1 == data_pos_s1) begin
			plain_word = data_s1;
		end else if (pos_s1 == POS_W'(0)) begin
			plain_word = SYNC_WORD;
		end else if (pos_s1 == POS_W'(1)) begin
			// header: sync tail, minute, second, frame, mode byte
			plain_word = {6'b0, mode_s1, !mode_s1,
				1'b0, frame_s1, 2'b0, second_s1, 2'b0, minute_s1,
				8'h00, SYNC_TAIL};
		end else if (pos_s1 == POS_W'(2)) begin
			plain_word = SUBHDR_WORD;
		end else begin
			plain_word = '0;   // zero tail
		end
	end

	assign phase = key_phase(pos_s1);

	// Bytes below sector offset 12 (all of word 0, low half of word 1) stay clear.
	always_comb begin
		logic [4:0] kidx;
		logic       en;
		scr_word = plain_word;
		for (int b = 0; b < 8; b++) begin
			kidx = 5'(phase) + 5'(b);
			if (kidx >= 5'd10) kidx = kidx - 5'd10;
			en = scr_s1 && (pos_s1 != POS_W'(0)) && !((pos_s1 == POS_W'(1)) && (b < 4));
			if (en) scr_word[8*b +: 8] = plain_word[8*b +: 8] ^ key_byte(kidx[3:0]);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: output register, parts the generator from downstream stall
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (emit) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			raw_word_s2 <= scr_word;
			last_s2     <= (pos_s1 == last_pos_s1);
			end_s2      <= tail_s1 && (pos_s1 == last_pos_s1);
		end
	end

	assign out_valid   = out_valid_s2;
	assign raw_word    = raw_word_s2;
	assign last_of_run = last_s2;
	assign sector_end  = end_s2;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
`include "cd_sector_framer_assert.svh"

	// sector end only ever closes a run
	`CDSF_ASSERT_NOW(a_end_is_last, out_valid_s2 && end_s2, last_s2)
	// the word walk never overshoots its job
	`CDSF_ASSERT_NOW(a_pos_bounded, job_valid_s1, pos_s1 <= last_pos_s1)
	// a held job keeps the input stalled
	`CDSF_ASSERT_NOW(a_busy_stalls, job_valid_s1 && !job_done, in_stall)
	// closing a sector moves the address on
	`CDSF_ASSERT_NEXT(a_addr_moves, in_xfer && (widx_q == LAST_WIDX),
		frame_q != $past(frame_q))

endmodule

`default_nettype wire
